[rtl/ngram_hash_embedding_index_core_defines.svh]
// Assertion macros shared by the n-gram hash embedding index RTL.
`ifndef NGRAM_HASH_EMBEDDING_INDEX_CORE_DEFINES_SVH
`define NGRAM_HASH_EMBEDDING_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NHE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nhe assertion failed");

// Next-cycle implication, disabled during reset.
`define NHE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nhe assertion failed");

`endif

[rtl/nhe_pkg.sv]
// Package with types, codes and constants of the n-gram hash embedding index.
package nhe_pkg;

   localparam int NGRAM_MAX_DEF = 5;
   localparam int HEADS_MAX_DEF = 16;
   localparam int TOKEN_W       = 31;
   localparam int WORD_W        = 64;
   localparam int HEADNUM_W     = 4;
   localparam int CNT_W         = 7;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_EOS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADS = 2'd2;

   typedef enum logic [1:0] {
      REQ_TOKEN  = 2'd0,
      REQ_MULT   = 2'd1,
      REQ_VOCAB  = 2'd2,
      REQ_OFFSET = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type       req_type;
      logic [30:0]        token_id;
      logic [3:0]         table_index;
      logic signed [63:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic [63:0] global_row;
      logic [3:0]  head_number;
      logic        last_head;
      logic        bad_metadata;
   } rsp_item_type;

   typedef struct packed {
      logic         en;
      req_code_type sel;
      logic [3:0]   index;
      logic [63:0]  data;
   } tbl_write_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK_RD,
      S_CHK_EV,
      S_MUL_RD,
      S_MUL_LO,
      S_MUL_HI,
      S_MUL_ACC,
      S_HD_RD,
      S_DIV_GO,
      S_DIV_WAIT
   } state_type;

endpackage

[rtl/nhe_tables.sv]
// Multiplier, vocab size and head offset memories with registered reads.
module nhe_tables #(
   parameter int NGRAM_MAX = nhe_pkg::NGRAM_MAX_DEF,
   parameter int HEADS_MAX = nhe_pkg::HEADS_MAX_DEF
) (
   input  logic                   clock,
   input  nhe_pkg::tbl_write_type wr,
   input  logic [$clog2(NGRAM_MAX)-1:0] mult_addr,
   input  logic [((HEADS_MAX > 1) ? $clog2(HEADS_MAX) : 1)-1:0] head_addr,
   output logic [63:0]            mult_q,
   output logic [63:0]            vocab_q,
   output logic [63:0]            offset_q
);

   localparam int MW = $clog2(NGRAM_MAX);
   localparam int HW = (HEADS_MAX > 1) ? $clog2(HEADS_MAX) : 1;

   logic [63:0] mult_mem   [NGRAM_MAX];
   logic [63:0] vocab_mem  [HEADS_MAX];
   logic [63:0] offset_mem [HEADS_MAX];

   logic [6:0] idx7;
   logic       mult_ok;
   logic       head_ok;

   assign idx7    = {3'b000, wr.index};
   assign mult_ok = idx7 < 7'(NGRAM_MAX);
   assign head_ok = idx7 < 7'(HEADS_MAX);

   always_ff @(posedge clock) begin
      if (wr.en && mult_ok && (wr.sel == nhe_pkg::REQ_MULT)) begin
         mult_mem[idx7[MW-1:0]] <= wr.data;
      end
      mult_q <= mult_mem[mult_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.en && head_ok && (wr.sel == nhe_pkg::REQ_VOCAB)) begin
         vocab_mem[idx7[HW-1:0]] <= wr.data;
      end
      if (wr.en && head_ok && (wr.sel == nhe_pkg::REQ_OFFSET)) begin
         offset_mem[idx7[HW-1:0]] <= wr.data;
      end
      vocab_q  <= vocab_mem[head_addr];
      offset_q <= offset_mem[head_addr];
   end

endmodule

[rtl/nhe_divider.sv]
// Bit-serial restoring divider that returns the 64-bit unsigned remainder.
`include "ngram_hash_embedding_index_core_defines.svh"

module nhe_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] rem
);

   localparam int IW = $clog2(nhe_pkg::WORD_W);

   logic [63:0]   rem_ff, rem_in;
   logic [63:0]   quo_ff, quo_in;
   logic [63:0]   div_ff, div_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [63:0]   rem_sh;

   assign rem_sh = {rem_ff[62:0], quo_ff[63]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // The remainder stays below a divisor under 2^63, so the shift cannot overflow.
         rem_in = (rem_sh >= div_ff) ? (rem_sh - div_ff) : rem_sh;
         quo_in = {quo_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IW'(nhe_pkg::WORD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   `NHE_ASSERT_IMP(a_div_no_restart, clock, reset, start, !run_ff)
   `NHE_ASSERT_NXT(a_div_done_pulse, clock, reset, done_ff, !done_ff && !run_ff)

endmodule

[rtl/ngram_hash_embedding_index_core.sv]
// Top level of the n-gram hash embedding index: sequencer, history and result register.
//
// One token command returns one result per head, each on rsp_data for a single cycle
// marked by rsp_valid; the receiver must take every strobe. Table and register writes
// take effect at once. A token first checks the vocab size and offset of all T heads,
// then forms the product of each of the N hashed positions (read, low half, high half,
// accumulate), and per head reads the tables, starts the bit-serial remainder and waits
// for it. A token that hits bad metadata at head k returns its error result at the end
// of the check of that head, and no other result. busy stays high until the last
// result of the token is on the ports.
`include "ngram_hash_embedding_index_core_defines.svh"

module ngram_hash_embedding_index_core #(
   parameter int NGRAM_MAX = nhe_pkg::NGRAM_MAX_DEF,
   parameter int HEADS_MAX = nhe_pkg::HEADS_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  nhe_pkg::req_item_type                req_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nhe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nhe_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_valid,
   output nhe_pkg::rsp_item_type                rsp_data
);

   localparam int HIST_DEPTH = NGRAM_MAX - 1;
   localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
   localparam int MW         = $clog2(NGRAM_MAX);
   localparam int HW         = (HEADS_MAX > 1) ? $clog2(HEADS_MAX) : 1;
   localparam int CW         = nhe_pkg::CNT_W;

   nhe_pkg::state_type    state_ff, state_in;
   logic [30:0]           eos_ff;
   logic [2:0]            order_ff;
   logic [2:0]            heads_cfg_ff;

   logic [30:0]           hist_ff [HIST_DEPTH];
   logic [30:0]           hist_in [HIST_DEPTH];
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [30:0]           shifted_ff  [NGRAM_MAX];
   logic [30:0]           shifted_in  [NGRAM_MAX];
   logic [30:0]           shifted_new [NGRAM_MAX];
   logic                  crossed;
   logic [30:0]           prev_tok;

   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [MW-1:0]         p_ff, p_in;
   logic [2:0]            h_ff, h_in;
   logic [2:0]            heads_ff, heads_in;
   logic [62:0]           plo_ff, plo_in;
   logic [31:0]           phi_ff, phi_in;
   logic [63:0]           mixed_ff, mixed_in;
   logic [63:0]           vocab_ff, vocab_in;
   logic [63:0]           offset_ff, offset_in;
   logic                  neg_ff, neg_in;
   nhe_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [3:0]            nmax;
   logic [2:0]            heads_eff;
   logic [CW-1:0]         total_raw;
   logic                  accept;
   logic [30:0]           tok_sel;
   logic                  bad_meta;
   logic                  is_last;
   logic [63:0]           rem_fix;

   nhe_pkg::tbl_write_type wr;
   logic [MW-1:0]          mult_addr;
   logic [HW-1:0]          head_addr;
   logic [63:0]            mult_q;
   logic [63:0]            vocab_q;
   logic [63:0]            offset_q;

   logic                   div_start;
   logic [63:0]            div_dividend;
   logic                   div_done;
   logic [63:0]            div_rem;

   nhe_tables #(
      .NGRAM_MAX (NGRAM_MAX),
      .HEADS_MAX (HEADS_MAX)
   ) u_tables (
      .clock     (clock),
      .wr        (wr),
      .mult_addr (mult_addr),
      .head_addr (head_addr),
      .mult_q    (mult_q),
      .vocab_q   (vocab_q),
      .offset_q  (offset_q)
   );

   nhe_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (vocab_q),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign accept    = start && (state_ff == nhe_pkg::S_IDLE);
   assign busy      = (state_ff != nhe_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   assign wr.en    = accept && (req_data.req_type != nhe_pkg::REQ_TOKEN);
   assign wr.sel   = req_data.req_type;
   assign wr.index = req_data.table_index;
   assign wr.data  = req_data.table_value;

   // Order and head count as seen by the sequencer, saturated into range.
   always_comb begin
      if (order_ff < 3'd2) begin
         nmax = 4'd2;
      end else if ({1'b0, order_ff} > 4'(NGRAM_MAX)) begin
         nmax = 4'(NGRAM_MAX);
      end else begin
         nmax = {1'b0, order_ff};
      end
      heads_eff = (heads_cfg_ff == 3'd0) ? 3'd1 : heads_cfg_ff;
      total_raw = CW'(nmax - 4'd1) * CW'(heads_eff);
   end

   // History walk: the first end-of-sequence token masks itself and everything older.
   always_comb begin
      crossed        = 1'b0;
      prev_tok       = eos_ff;
      shifted_new[0] = req_data.token_id;
      for (int s = 1; s < NGRAM_MAX; s++) begin
         prev_tok = (FILL_W'(s - 1) < fill_ff) ? hist_ff[s-1] : eos_ff;
         if (prev_tok == eos_ff) begin
            crossed = 1'b1;
         end
         shifted_new[s] = crossed ? eos_ff : prev_tok;
      end
   end

   assign tok_sel   = shifted_ff[p_ff];
   assign mult_addr = p_ff;
   assign head_addr = cnt_ff[HW-1:0];
   assign bad_meta  = (vocab_q == 64'd0) || vocab_q[63] || offset_q[63];
   assign is_last   = (cnt_ff + 1'b1) == total_ff;
   assign rem_fix   = (neg_ff && (div_rem != 64'd0)) ? (vocab_ff - div_rem) : div_rem;
   assign div_start    = (state_ff == nhe_pkg::S_DIV_GO);
   assign div_dividend = mixed_ff[63] ? (~mixed_ff + 64'd1) : mixed_ff;

   always_comb begin
      state_in     = state_ff;
      hist_in      = hist_ff;
      fill_in      = fill_ff;
      shifted_in   = shifted_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      p_in         = p_ff;
      h_in         = h_ff;
      heads_in     = heads_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      mixed_in     = mixed_ff;
      vocab_in     = vocab_ff;
      offset_in    = offset_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         nhe_pkg::S_IDLE: begin
            if (accept && (req_data.req_type == nhe_pkg::REQ_TOKEN)) begin
               shifted_in = shifted_new;
               heads_in   = heads_eff;
               total_in   = (total_raw > CW'(HEADS_MAX)) ? CW'(HEADS_MAX) : total_raw;
               cnt_in     = '0;
               p_in       = '0;
               h_in       = '0;
               mixed_in   = '0;
               state_in   = nhe_pkg::S_CHK_RD;
            end
         end
         nhe_pkg::S_CHK_RD: begin
            state_in = nhe_pkg::S_CHK_EV;
         end
         nhe_pkg::S_CHK_EV: begin
            if (bad_meta) begin
               rsp_in.global_row   = '0;
               rsp_in.head_number  = cnt_ff[3:0];
               rsp_in.last_head    = 1'b1;
               rsp_in.bad_metadata = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = nhe_pkg::S_IDLE;
            end else if (is_last) begin
               cnt_in   = '0;
               state_in = nhe_pkg::S_MUL_RD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = nhe_pkg::S_CHK_RD;
            end
         end
         nhe_pkg::S_MUL_RD: begin
            state_in = nhe_pkg::S_MUL_LO;
         end
         nhe_pkg::S_MUL_LO: begin
            plo_in   = {32'd0, tok_sel} * {31'd0, mult_q[31:0]};
            state_in = nhe_pkg::S_MUL_HI;
         end
         nhe_pkg::S_MUL_HI: begin
            phi_in   = {1'b0, tok_sel} * mult_q[63:32];
            state_in = nhe_pkg::S_MUL_ACC;
         end
         nhe_pkg::S_MUL_ACC: begin
            mixed_in = mixed_ff ^ ({1'b0, plo_ff} + {phi_ff, 32'd0});
            // Order n is ready once the products of positions 0 to n-1 are in.
            if (p_ff == '0) begin
               p_in     = p_ff + 1'b1;
               state_in = nhe_pkg::S_MUL_RD;
            end else begin
               h_in     = '0;
               state_in = nhe_pkg::S_HD_RD;
            end
         end
         nhe_pkg::S_HD_RD: begin
            state_in = nhe_pkg::S_DIV_GO;
         end
         nhe_pkg::S_DIV_GO: begin
            vocab_in  = vocab_q;
            offset_in = offset_q;
            neg_in    = mixed_ff[63];
            state_in  = nhe_pkg::S_DIV_WAIT;
         end
         nhe_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               rsp_in.global_row   = rem_fix + offset_ff;
               rsp_in.head_number  = cnt_ff[3:0];
               rsp_in.last_head    = is_last;
               rsp_in.bad_metadata = 1'b0;
               rsp_valid_in        = 1'b1;
               if (is_last) begin
                  for (int s = HIST_DEPTH - 1; s > 0; s--) begin
                     hist_in[s] = hist_ff[s-1];
                  end
                  hist_in[0] = shifted_ff[0];
                  if (fill_ff < FILL_W'(HIST_DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  state_in = nhe_pkg::S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  if ((h_ff + 3'd1) == heads_ff) begin
                     p_in     = p_ff + 1'b1;
                     state_in = nhe_pkg::S_MUL_RD;
                  end else begin
                     h_in     = h_ff + 3'd1;
                     state_in = nhe_pkg::S_HD_RD;
                  end
               end
            end
         end
         default: begin
            state_in = nhe_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nhe_pkg::S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         eos_ff       <= '0;
         order_ff     <= 3'd2;
         heads_cfg_ff <= 3'd1;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               nhe_pkg::CSR_EOS:   eos_ff       <= csr_wdata[30:0];
               nhe_pkg::CSR_ORDER: order_ff     <= csr_wdata[2:0];
               nhe_pkg::CSR_HEADS: heads_cfg_ff <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hist_ff    <= hist_in;
      shifted_ff <= shifted_in;
      cnt_ff     <= cnt_in;
      total_ff   <= total_in;
      p_ff       <= p_in;
      h_ff       <= h_in;
      heads_ff   <= heads_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      mixed_ff   <= mixed_in;
      vocab_ff   <= vocab_in;
      offset_ff  <= offset_in;
      neg_ff     <= neg_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `NHE_ASSERT_IMP(a_err_form, clock, reset, rsp_valid_ff && rsp_ff.bad_metadata, rsp_ff.last_head && (rsp_ff.global_row == 64'd0))
   `NHE_ASSERT_IMP(a_last_frees, clock, reset, rsp_valid_ff && rsp_ff.last_head, !busy)
   `NHE_ASSERT_IMP(a_cnt_range, clock, reset, state_ff != nhe_pkg::S_IDLE, cnt_ff < total_ff)

endmodule
